// File: hdl/chs_pkg.sv
// Shared types and constants for the chained hash set.
package chs_pkg;

   localparam int KEY_W           = 31;
   localparam int SLOT_W          = 6;
   localparam int DIGIT_W         = 4;
   localparam int MOD_STEPS       = 8;
   localparam int MOD_W           = DIGIT_W * MOD_STEPS;
   localparam int STEP_W          = $clog2(MOD_STEPS);
   localparam int DEFAULT_BUCKETS = 11;
   localparam int DEFAULT_NODES   = 64;

   typedef enum logic [2:0] {
      ST_MISS     = 3'd0,
      ST_HIT      = 3'd1,
      ST_INSERTED = 3'd2,
      ST_DUP      = 3'd3,
      ST_FULL     = 3'd4
   } chs_status_type;

   typedef enum logic {
      OP_SEARCH = 1'b0,
      OP_INSERT = 1'b1
   } chs_op_type;

   typedef struct packed {
      chs_op_type         req_type;
      logic [KEY_W-1:0]   key;
   } chs_req_type;

   typedef struct packed {
      chs_status_type     status;
      logic [SLOT_W-1:0]  slot;
   } chs_rsp_type;

endpackage

// File: hdl/chained_hash_set_top.sv
// Hash set with separate chaining over a bucket-head memory and a node memory.
//
//   channel   ports                          handshake
//   request   start, busy, req_data          beat taken when start && !busy
//   response  rsp_strobe, rsp_data           beat valid for one cycle, no stall
//
// The bucket index takes MOD_STEPS steps (four key bits reduced per cycle).
// A request then reads its bucket head and walks the chain; each chain node
// visited costs one node-memory read and one compare. After reset the block
// clears the bucket heads, one per cycle, with busy high. The response side
// cannot stall; a response beat may go out in the cycle the next request is taken.
module chained_hash_set_top #(
   parameter int BUCKETS = chs_pkg::DEFAULT_BUCKETS,
   parameter int NODES   = chs_pkg::DEFAULT_NODES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  chs_pkg::chs_req_type req_data,
   output logic                 rsp_strobe,
   output chs_pkg::chs_rsp_type rsp_data
);
   import chs_pkg::*;

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int LW = $clog2(NODES + 1);
   localparam int VW = BW + DIGIT_W;
   localparam logic [LW-1:0] NIL = LW'(NODES);

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [LW-1:0]    link;
   } node_type;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_MOD   = 7'b0000100,
      S_HEAD  = 7'b0001000,
      S_PTR   = 7'b0010000,
      S_ISSUE = 7'b0100000,
      S_CMP   = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [BW-1:0]       clr_ff, clr_in;
   logic [BW-1:0]       rem_ff, rem_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [MOD_W-1:0]    key_sh_ff, key_sh_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   chs_op_type          op_ff, op_in;
   logic [LW-1:0]       used_ff, used_in;
   logic [LW-1:0]       ptr_ff, ptr_in;
   logic [LW-1:0]       head_q_ff;
   node_type            node_q_ff;
   chs_rsp_type         rsp_ff, rsp_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   logic [LW-1:0]       head_mem [BUCKETS];
   node_type            node_mem [NODES];

   logic                head_we;
   logic [BW-1:0]       head_wa;
   logic [LW-1:0]       head_wd;
   logic                node_we;
   node_type            node_wd;
   logic [VW-1:0]       mod_v;
   logic [VW-1:0]       mod_r;
   logic                finish;
   logic                found;

   always_comb begin
      mod_v = {rem_ff, key_sh_ff[MOD_W-1 -: DIGIT_W]};
      mod_r = mod_v;
      for (int m = 1; m < (1 << DIGIT_W); m++) begin
         if (mod_v >= VW'(m * BUCKETS)) begin
            mod_r = mod_v - VW'(m * BUCKETS);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      rem_in        = rem_ff;
      key_in        = key_ff;
      key_sh_in     = key_sh_ff;
      step_in       = step_ff;
      op_in         = op_ff;
      used_in       = used_ff;
      ptr_in        = ptr_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      head_we       = 1'b0;
      head_wa       = rem_ff;
      head_wd       = used_ff;
      node_we       = 1'b0;
      node_wd       = '{key: key_ff, link: head_q_ff};
      finish        = 1'b0;
      found         = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            head_we = 1'b1;
            head_wa = clr_ff;
            head_wd = NIL;
            if (clr_ff == BW'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (start) begin
               key_in    = req_data.key;
               key_sh_in = MOD_W'(req_data.key);
               op_in     = req_data.req_type;
               rem_in    = '0;
               step_in   = '0;
               state_in  = S_MOD;
            end
         end
         S_MOD: begin
            rem_in    = BW'(mod_r);
            key_sh_in = key_sh_ff << DIGIT_W;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(MOD_STEPS - 1)) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            state_in = S_PTR;
         end
         S_PTR: begin
            ptr_in   = head_q_ff;
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            if (ptr_ff < used_ff) begin
               state_in = S_CMP;
            end else begin
               finish = 1'b1;
            end
         end
         S_CMP: begin
            if (node_q_ff.key == key_ff) begin
               finish = 1'b1;
               found  = 1'b1;
            end else begin
               ptr_in   = node_q_ff.link;
               state_in = S_ISSUE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         state_in      = S_IDLE;
         rsp_strobe_in = 1'b1;
         if (found) begin
            rsp_in.status = (op_ff == OP_INSERT) ? ST_DUP : ST_HIT;
            rsp_in.slot   = SLOT_W'(ptr_ff);
         end else if (op_ff == OP_SEARCH) begin
            rsp_in.status = ST_MISS;
            rsp_in.slot   = '0;
         end else if (used_ff == NIL) begin
            rsp_in.status = ST_FULL;
            rsp_in.slot   = '0;
         end else begin
            rsp_in.status = ST_INSERTED;
            rsp_in.slot   = SLOT_W'(used_ff);
            node_we       = 1'b1;
            head_we       = 1'b1;
            used_in       = used_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_q_ff <= head_mem[rem_ff];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[used_ff[NW-1:0]] <= node_wd;
      end
      node_q_ff <= node_mem[ptr_ff[NW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rem_ff    <= rem_in;
      key_ff    <= key_in;
      key_sh_ff <= key_sh_in;
      step_ff   <= step_in;
      op_ff     <= op_in;
      ptr_ff    <= ptr_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: test/chained_hash_set_top_test.sv
// Self-checking testbench for chained_hash_set_top: search and insert beats checked against a behavioral hash set.
`timescale 1ns / 100ps

module chained_hash_set_top_test;
   import chs_pkg::*;

   localparam int BUCKETS = DEFAULT_BUCKETS;
   localparam int NODES   = DEFAULT_NODES;
   localparam int RANDOM_REQS = 1250;
   localparam int QUIET_TAIL  = 150;
   localparam int DRAIN_CYCLES = 160;
   localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   chs_req_type req_data = '0;
   logic        rsp_strobe;
   chs_rsp_type rsp_data;

   chs_req_type      req_backlog[$];
   chs_rsp_type      pending_results[$];
   logic [KEY_W-1:0] insert_keys[$];
   bit               req_taken;
   int               idle_left;
   int               error_count;
   int               beats_taken;
   int               status_seen[5];

   logic [KEY_W-1:0] hset_key[NODES];
   int               hset_link[NODES];
   int               hset_head[BUCKETS];
   int               hset_used;

   chained_hash_set_top #(
      .BUCKETS(BUCKETS),
      .NODES  (NODES)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic chs_rsp_type hash_set_apply(chs_req_type req);
      int          b;
      int          p;
      int          steps;
      int          found;
      chs_rsp_type r;
      b = int'(req.key % BUCKETS);
      p = hset_head[b];
      steps = 0;
      found = NODES;
      while (found == NODES && p < hset_used && p < NODES && steps < NODES) begin
         if (hset_key[p] == req.key) begin
            found = p;
         end else begin
            p = hset_link[p];
            steps++;
         end
      end
      r.slot = '0;
      if (req.req_type == OP_SEARCH) begin
         if (found != NODES) begin
            r.status = ST_HIT;
            r.slot = SLOT_W'(found);
         end else begin
            r.status = ST_MISS;
         end
      end else if (found != NODES) begin
         r.status = ST_DUP;
         r.slot = SLOT_W'(found);
      end else if (hset_used >= NODES) begin
         r.status = ST_FULL;
      end else begin
         hset_key[hset_used] = req.key;
         hset_link[hset_used] = hset_head[b];
         hset_head[b] = hset_used;
         r.status = ST_INSERTED;
         r.slot = SLOT_W'(hset_used);
         hset_used++;
      end
      return r;
   endfunction

   task automatic queue_req(chs_op_type op, logic [KEY_W-1:0] key);
      chs_req_type req;
      req.req_type = op;
      req.key = key;
      req_backlog.push_back(req);
      if (op == OP_INSERT)
         insert_keys.push_back(key);
   endtask

   // request driver: hold a beat until taken, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (req_backlog.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            idle_left = $urandom_range(1, 9) - 1;
            start <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            req_data <= req_backlog.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // response monitor and request tap
   always @(posedge clock) begin
      chs_rsp_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               $error("unexpected response beat: status %0d slot %0d",
                      rsp_data.status, rsp_data.slot);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               status_seen[int'(want.status)]++;
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.slot !== want.slot) begin
                  $error("slot: expected %0d, actual %0d", want.slot, rsp_data.slot);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            req_taken = 1'b1;
            beats_taken++;
            pending_results.push_back(hash_set_apply(req_data));
         end
      end
   end

   initial begin
      chs_op_type       op;
      logic [KEY_W-1:0] key;
      int               sel;
      for (int i = 0; i < BUCKETS; i++)
         hset_head[i] = NODES;
      hset_used = 0;

      queue_req(OP_SEARCH, '0);
      queue_req(OP_SEARCH, KEY_MAX);
      queue_req(OP_INSERT, '0);
      queue_req(OP_INSERT, '0);
      queue_req(OP_SEARCH, '0);
      queue_req(OP_INSERT, KEY_MAX);
      queue_req(OP_SEARCH, KEY_MAX);
      queue_req(OP_INSERT, KEY_MAX);
      queue_req(OP_INSERT, 31'd11);
      queue_req(OP_INSERT, 31'd22);
      queue_req(OP_INSERT, 31'd33);
      queue_req(OP_SEARCH, '0);
      queue_req(OP_SEARCH, 31'd44);
      queue_req(OP_INSERT, 31'd22);
      queue_req(OP_SEARCH, 31'd11);
      queue_req(OP_INSERT, 31'h2AAAAAAA);
      queue_req(OP_INSERT, 31'h55555555);
      queue_req(OP_SEARCH, 31'h2AAAAAAA);
      queue_req(OP_SEARCH, 31'h55555555);
      queue_req(OP_SEARCH, 31'd1);
      queue_req(OP_SEARCH, 31'h7FFFFFF0);

      // mostly known keys and a dense low range so chains grow long and the pool fills
      for (int i = 0; i < RANDOM_REQS; i++) begin
         op = chs_op_type'($urandom_range(0, 1));
         sel = $urandom_range(0, 9);
         if (sel < 5)
            key = insert_keys[$urandom_range(0, insert_keys.size() - 1)];
         else if (sel < 8)
            key = KEY_W'($urandom_range(0, 300));
         else
            key = KEY_W'($urandom());
         queue_req(op, key);
      end

      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (req_backlog.size() != 0 || start || pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests, %0d of %0d pool nodes used.", beats_taken, hset_used, NODES);
      $display("Responses: %0d miss, %0d hit, %0d inserted, %0d duplicate, %0d pool full.",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("chained_hash_set_top verification clean");
      end else begin
         $display("chained_hash_set_top verification failed");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("chained_hash_set_top verification failed");
      $finish;
   end

endmodule

// File: files.f
hdl/chs_pkg.sv
hdl/chained_hash_set_top.sv
test/chained_hash_set_top_test.sv
